// File: design/blz_pkg.sv
package blz_pkg;

    localparam int BYTE_W = 8;
    localparam int SIZE_W = 26;
    localparam int DIST_W = 13;
    localparam int LEN_W = 5;
    localparam int FLAGS_W = 4;
    localparam int HISTORY_DEPTH_DEF = 8192;

    localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);
    localparam logic [DIST_W-1:0] DIST_BIAS = DIST_W'(3);
    localparam logic [FLAGS_W-1:0] FLAGS_PER_CTRL = FLAGS_W'(8);

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_FLAG = 2'd1,
        PH_TOKEN_LOW = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] comp_byte;
        logic last_byte;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [SIZE_W-1:0] out_position;
        logic run_end;
        logic status;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic set_flags;
        logic set_token;
        logic emit_lit;
        logic emit_err;
        logic start_copy;
        logic copy_emit;
        logic next_flag;
        logic set_err;
        logic start_run;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic err_seen;
        t_phase phase;
        logic lit;
        logic in_last;
        logic lit_full;
        logic tok_bad;
        logic out_free;
        logic copy_last;
    } t_stat;

endpackage

// File: design/backward_lz77_decoder.sv
// a literal or error result is latched with its input byte, then registered at the output
// a control byte, literal or token high byte is evaluated before the next input is taken;
//   a token low byte starts a copy of 3 to 18 bytes (one history read per byte)
// output stalls can hold evaluation and copy; the next input is taken while a result waits
// reset: synchronous active low, clears control state; history ring is not cleared
module backward_lz77_decoder #(
    parameter int HISTORY_DEPTH = blz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  blz_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output blz_pkg::t_out              o_out,
    input  logic                       i_cfg_wr_en,
    input  logic [blz_pkg::SIZE_W-1:0] i_cfg_wr_data
);

    blz_pkg::t_cmd  cmd;
    blz_pkg::t_stat stat;

    blz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    blz_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out)
    );

endmodule

// File: design/blz_ctrl.sv
module blz_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  blz_pkg::t_stat i_stat,
    output blz_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_COPY = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.err_seen) begin
                    // items after an error are dropped until the end of region
                    o_cmd.start_run = i_stat.in_last;
                    n_state = S_IDLE;
                end else begin
                    case (i_stat.phase)
                        blz_pkg::PH_CONTROL: begin
                            o_cmd.set_flags = 1'b1;
                            o_cmd.start_run = i_stat.in_last;
                            n_state = S_IDLE;
                        end
                        blz_pkg::PH_FLAG: begin
                            if (i_stat.lit) begin
                                if (i_stat.out_free) begin
                                    if (i_stat.lit_full) begin
                                        o_cmd.emit_err = 1'b1;
                                        o_cmd.set_err = !i_stat.in_last;
                                    end else begin
                                        o_cmd.emit_lit = 1'b1;
                                        o_cmd.next_flag = 1'b1;
                                    end
                                    o_cmd.start_run = i_stat.in_last;
                                    n_state = S_IDLE;
                                end
                            end else if (!i_stat.in_last) begin
                                o_cmd.set_token = 1'b1;
                                n_state = S_IDLE;
                            end else if (i_stat.out_free) begin
                                // token cut off by the end of region
                                o_cmd.emit_err = 1'b1;
                                o_cmd.start_run = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        blz_pkg::PH_TOKEN_LOW: begin
                            if (!i_stat.tok_bad) begin
                                o_cmd.start_copy = 1'b1;
                                n_state = S_COPY;
                            end else if (i_stat.out_free) begin
                                o_cmd.emit_err = 1'b1;
                                o_cmd.set_err = !i_stat.in_last;
                                o_cmd.start_run = i_stat.in_last;
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY: begin
                if (i_stat.out_free) begin
                    o_cmd.copy_emit = 1'b1;
                    if (i_stat.copy_last) begin
                        o_cmd.next_flag = 1'b1;
                        o_cmd.start_run = i_stat.in_last;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/blz_dpath.sv
module blz_dpath #(
    parameter int HISTORY_DEPTH = blz_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blz_pkg::t_in                i_in,
    input  logic                        i_cfg_wr_en,
    input  logic [blz_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  blz_pkg::t_cmd               i_cmd,
    output blz_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output blz_pkg::t_out               o_out
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] DEPTH_V = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] PTR_MAX = AW'(HISTORY_DEPTH - 1);

    logic [blz_pkg::SIZE_W-1:0]  r_output_size;
    blz_pkg::t_in                r_in;
    blz_pkg::t_phase             r_phase, n_phase;
    logic [blz_pkg::BYTE_W-1:0]  r_flag_bits, n_flag_bits;
    logic [blz_pkg::FLAGS_W-1:0] r_flags_left, n_flags_left;
    logic [blz_pkg::BYTE_W-1:0]  r_token_high, n_token_high;
    logic [blz_pkg::SIZE_W-1:0]  r_produced, n_produced;
    logic                        r_err_seen, n_err_seen;
    logic [AW-1:0]               r_wptr, n_wptr;
    logic [AW-1:0]               r_src, n_src;
    logic [blz_pkg::LEN_W-1:0]   r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    blz_pkg::t_out               r_out;

    logic [blz_pkg::BYTE_W-1:0]  mem [HISTORY_DEPTH];
    logic [blz_pkg::BYTE_W-1:0]  r_rd_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [blz_pkg::BYTE_W-1:0]  wr_data;

    logic [blz_pkg::LEN_W-1:0]   tok_len;
    logic [blz_pkg::DIST_W-1:0]  tok_dist;
    logic [AW:0]                 src_diff;
    logic [AW-1:0]               src_start;
    logic [AW-1:0]               src_inc;
    logic [AW-1:0]               wptr_inc;
    logic [blz_pkg::SIZE_W:0]    end_count;
    logic [blz_pkg::SIZE_W-1:0]  position;
    logic                        out_free;

    assign tok_len = blz_pkg::LEN_W'(r_token_high[7:4]) + blz_pkg::LEN_BIAS;
    assign tok_dist = {1'b0, r_token_high[3:0], r_in.comp_byte} + blz_pkg::DIST_BIAS;
    assign end_count = {1'b0, r_produced} + (blz_pkg::SIZE_W+1)'(tok_len);

    // ring offset back by the distance, distance below the default depth
    assign src_diff = {1'b0, r_wptr} - (AW+1)'(tok_dist);
    assign src_start = src_diff[AW] ? AW'(src_diff + DEPTH_V) : src_diff[AW-1:0];
    assign src_inc = (r_src == PTR_MAX) ? '0 : r_src + AW'(1);
    assign wptr_inc = (r_wptr == PTR_MAX) ? '0 : r_wptr + AW'(1);

    // output_size - produced - 1
    assign position = r_output_size + ~r_produced;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.err_seen = r_err_seen;
        o_stat.phase = r_phase;
        o_stat.lit = !r_flag_bits[7];
        o_stat.in_last = r_in.last_byte;
        o_stat.lit_full = (r_produced >= r_output_size);
        o_stat.tok_bad = ((blz_pkg::SIZE_W)'(tok_dist) > r_produced)
            || (end_count > {1'b0, r_output_size});
        o_stat.out_free = out_free;
        o_stat.copy_last = (r_cnt == blz_pkg::LEN_W'(1));
    end

    always_comb begin
        n_phase = r_phase;
        n_flag_bits = r_flag_bits;
        n_flags_left = r_flags_left;
        n_token_high = r_token_high;
        n_produced = r_produced;
        n_err_seen = r_err_seen;
        n_wptr = r_wptr;
        n_src = r_src;
        n_cnt = r_cnt;
        rd_en = 1'b0;
        rd_addr = r_src;
        wr_en = 1'b0;
        wr_data = r_rd_data;

        if (i_cmd.set_flags) begin
            n_flag_bits = r_in.comp_byte;
            n_flags_left = blz_pkg::FLAGS_PER_CTRL;
            n_phase = blz_pkg::PH_FLAG;
        end
        if (i_cmd.set_token) begin
            n_token_high = r_in.comp_byte;
            n_phase = blz_pkg::PH_TOKEN_LOW;
        end
        if (i_cmd.emit_lit) begin
            wr_en = 1'b1;
            wr_data = r_in.comp_byte;
        end
        if (i_cmd.start_copy) begin
            n_cnt = tok_len;
            n_src = src_start;
            rd_en = 1'b1;
            rd_addr = src_start;
        end
        if (i_cmd.copy_emit) begin
            wr_en = 1'b1;
            n_cnt = r_cnt - blz_pkg::LEN_W'(1);
            n_src = src_inc;
            // fetch the next source byte, at least two bytes behind this write
            rd_en = !o_stat.copy_last;
            rd_addr = src_inc;
        end
        if (wr_en) begin
            n_produced = r_produced + blz_pkg::SIZE_W'(1);
            n_wptr = wptr_inc;
        end
        if (i_cmd.next_flag) begin
            n_flag_bits = {r_flag_bits[6:0], 1'b0};
            n_flags_left = r_flags_left - blz_pkg::FLAGS_W'(1);
            n_phase = (n_flags_left == '0) ? blz_pkg::PH_CONTROL : blz_pkg::PH_FLAG;
        end
        if (i_cmd.set_err) begin
            n_err_seen = 1'b1;
        end
        if (i_cmd.start_run) begin
            n_phase = blz_pkg::PH_CONTROL;
            n_flag_bits = '0;
            n_flags_left = '0;
            n_token_high = '0;
            n_produced = '0;
            n_err_seen = 1'b0;
            n_wptr = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit_lit || i_cmd.emit_err || i_cmd.copy_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_size <= '0;
            r_phase <= blz_pkg::PH_CONTROL;
            r_flag_bits <= '0;
            r_flags_left <= '0;
            r_token_high <= '0;
            r_produced <= '0;
            r_err_seen <= 1'b0;
            r_wptr <= '0;
            r_src <= '0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_output_size <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_flag_bits <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_token_high <= n_token_high;
            r_produced <= n_produced;
            r_err_seen <= n_err_seen;
            r_wptr <= n_wptr;
            r_src <= n_src;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in;
        end
        if (i_cmd.emit_lit) begin
            r_out.out_byte <= r_in.comp_byte;
            r_out.out_position <= position;
            r_out.run_end <= 1'b1;
            r_out.status <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_out.out_byte <= '0;
            r_out.out_position <= '0;
            r_out.run_end <= 1'b1;
            r_out.status <= 1'b1;
        end else if (i_cmd.copy_emit) begin
            r_out.out_byte <= r_rd_data;
            r_out.out_position <= position;
            r_out.run_end <= o_stat.copy_last;
            r_out.status <= 1'b0;
        end
    end

    // history ring, read data held until the next fetch
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wptr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule
